// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== hw/rtl/mdfts_pkg.sv =====
// ----------------------------------------------------------------------------
// mdfts_pkg
// Types, constants and the per-offset scan step of the markdown token scanner.
// ----------------------------------------------------------------------------
package mdfts_pkg;

    localparam int CHAR_W       = 8;
    localparam int KIND_W       = 5;
    localparam int TOKEN_POS_W  = 12;
    localparam int M_TDATA_W    = 24;
    localparam int MAX_LINE_DEF = 4096;

    typedef logic [CHAR_W-1:0]      char_t;
    typedef logic [TOKEN_POS_W-1:0] tpos_t;

    typedef enum logic [KIND_W-1:0] {
        K_NONE   = 5'd0,
        K_ESCAPE = 5'd1,
        K_QBLOCK = 5'd2,
        K_LBREAK = 5'd3,
        K_COPEN  = 5'd4,
        K_CCLOSE = 5'd5,
        K_RULE   = 5'd6,
        K_H1     = 5'd7,
        K_H2     = 5'd8,
        K_H3     = 5'd9,
        K_H1LINE = 5'd10,
        K_ITALIC = 5'd11,
        K_BOLD   = 5'd12,
        K_STRIKE = 5'd13,
        K_ITEM   = 5'd14,
        K_TAB    = 5'd15,
        K_UNDER  = 5'd16,
        K_CODE   = 5'd17,
        K_AMP    = 5'd18,
        K_ENUM   = 5'd19,
        K_COLSEP = 5'd20,
        K_IMAGE  = 5'd21,
        K_LINK   = 5'd22,
        K_DQL    = 5'd23,
        K_DQR    = 5'd24,
        K_SQL    = 5'd25,
        K_SQR    = 5'd26,
        K_MATH   = 5'd27
    } token_kind_t;

    localparam char_t CH_NUL    = 8'h00;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_BANG   = 8'h21;
    localparam char_t CH_DQUOTE = 8'h22;
    localparam char_t CH_HASH   = 8'h23;
    localparam char_t CH_DOLLAR = 8'h24;
    localparam char_t CH_AMP    = 8'h26;
    localparam char_t CH_SQUOTE = 8'h27;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_PLUS   = 8'h2B;
    localparam char_t CH_DASH   = 8'h2D;
    localparam char_t CH_DOT    = 8'h2E;
    localparam char_t CH_ZERO   = 8'h30;
    localparam char_t CH_NINE   = 8'h39;
    localparam char_t CH_LT     = 8'h3C;
    localparam char_t CH_EQ     = 8'h3D;
    localparam char_t CH_GT     = 8'h3E;
    localparam char_t CH_LBRACK = 8'h5B;
    localparam char_t CH_BSLASH = 8'h5C;
    localparam char_t CH_UNDER  = 8'h5F;
    localparam char_t CH_BTICK  = 8'h60;
    localparam char_t CH_PIPE   = 8'h7C;
    localparam char_t CH_TILDE  = 8'h7E;

    typedef struct packed {
        token_kind_t kind;
        logic        off;
    } class_t;

    typedef struct packed {
        logic        found;
        token_kind_t kind;
        tpos_t       pos;
        logic        in_run;
        tpos_t       run_start;
    } scan_st_t;

    typedef struct packed {
        logic        too_long;
        tpos_t       pos;
        token_kind_t kind;
    } result_t;

    // One offset: digit-run tracking, then the pattern class.
    function automatic scan_st_t examine_step(scan_st_t st, char_t a, class_t cls,
                                              logic testable, tpos_t p);
        scan_st_t r;
        logic     digit;
        logic     enum_hit;
        r        = st;
        digit    = (a inside {[CH_ZERO:CH_NINE]});
        enum_hit = 1'b0;
        if (!st.found && testable && !(st.in_run && digit))
        begin
            if (st.in_run)
            begin
                r.in_run = 1'b0;
                if (a == CH_DOT || a == CH_RPAREN)
                begin
                    enum_hit = 1'b1;
                    r.found  = 1'b1;
                    r.kind   = K_ENUM;
                    r.pos    = st.run_start;
                end
            end
            if (!enum_hit)
            begin
                if (digit)
                begin
                    r.in_run    = 1'b1;
                    r.run_start = p;
                end
                else if (cls.kind != K_NONE)
                begin
                    r.found = 1'b1;
                    r.kind  = cls.kind;
                    r.pos   = p + tpos_t'(cls.off);
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mdfts_classify.sv =====
// ----------------------------------------------------------------------------
// mdfts_classify
// Priority pattern match of one offset over a four-byte lookahead window.
// ----------------------------------------------------------------------------
module mdfts_classify
(
    input  mdfts_pkg::char_t  a,
    input  mdfts_pkg::char_t  b,
    input  mdfts_pkg::char_t  c,
    input  mdfts_pkg::char_t  d,
    output mdfts_pkg::class_t cls
);

    always_comb
    begin
        cls.off  = 1'b0;
        cls.kind = mdfts_pkg::K_NONE;
        if (a == mdfts_pkg::CH_BSLASH && b != mdfts_pkg::CH_BSLASH)
            cls.kind = mdfts_pkg::K_ESCAPE;
        else if (a == mdfts_pkg::CH_GT)
            cls.kind = mdfts_pkg::K_QBLOCK;
        else if (a == mdfts_pkg::CH_SPACE && b == mdfts_pkg::CH_SPACE
                 && c == mdfts_pkg::CH_NUL)
            cls.kind = mdfts_pkg::K_LBREAK;
        else if (a == mdfts_pkg::CH_LT && b == mdfts_pkg::CH_BANG
                 && c == mdfts_pkg::CH_DASH && d == mdfts_pkg::CH_DASH)
            cls.kind = mdfts_pkg::K_COPEN;
        else if (a == mdfts_pkg::CH_DASH && b == mdfts_pkg::CH_DASH
                 && c == mdfts_pkg::CH_GT)
            cls.kind = mdfts_pkg::K_CCLOSE;
        else if ((a == mdfts_pkg::CH_DASH && b == mdfts_pkg::CH_DASH
                  && c == mdfts_pkg::CH_DASH)
                 || (a == mdfts_pkg::CH_STAR && b == mdfts_pkg::CH_STAR
                  && c == mdfts_pkg::CH_STAR))
            cls.kind = mdfts_pkg::K_RULE;
        else if (a == mdfts_pkg::CH_HASH && b != mdfts_pkg::CH_HASH)
            cls.kind = mdfts_pkg::K_H1;
        else if (a == mdfts_pkg::CH_HASH && b == mdfts_pkg::CH_HASH
                 && c != mdfts_pkg::CH_HASH)
            cls.kind = mdfts_pkg::K_H2;
        else if (a == mdfts_pkg::CH_HASH && b == mdfts_pkg::CH_HASH
                 && c == mdfts_pkg::CH_HASH && d != mdfts_pkg::CH_HASH)
            cls.kind = mdfts_pkg::K_H3;
        else if (a == mdfts_pkg::CH_EQ && b == mdfts_pkg::CH_EQ
                 && c == mdfts_pkg::CH_EQ)
            cls.kind = mdfts_pkg::K_H1LINE;
        else if (a == mdfts_pkg::CH_STAR && b != mdfts_pkg::CH_STAR)
            cls.kind = mdfts_pkg::K_ITALIC;
        else if (a == mdfts_pkg::CH_STAR)
            cls.kind = mdfts_pkg::K_BOLD;
        else if (a == mdfts_pkg::CH_TILDE && b == mdfts_pkg::CH_TILDE)
            cls.kind = mdfts_pkg::K_STRIKE;
        else if (a == mdfts_pkg::CH_PLUS || a == mdfts_pkg::CH_DASH)
            cls.kind = mdfts_pkg::K_ITEM;
        else if (a == mdfts_pkg::CH_TAB
                 || (a == mdfts_pkg::CH_SPACE && b == mdfts_pkg::CH_SPACE
                  && c == mdfts_pkg::CH_SPACE && d == mdfts_pkg::CH_SPACE))
            cls.kind = mdfts_pkg::K_TAB;
        else if (a == mdfts_pkg::CH_UNDER && b != mdfts_pkg::CH_UNDER)
            cls.kind = mdfts_pkg::K_UNDER;
        else if (a == mdfts_pkg::CH_BTICK && b == mdfts_pkg::CH_BTICK
                 && c == mdfts_pkg::CH_BTICK)
            cls.kind = mdfts_pkg::K_CODE;
        else if (a == mdfts_pkg::CH_AMP)
            cls.kind = mdfts_pkg::K_AMP;
        else if (a == mdfts_pkg::CH_PIPE)
            cls.kind = mdfts_pkg::K_COLSEP;
        else if (a == mdfts_pkg::CH_BANG && b == mdfts_pkg::CH_LBRACK)
            cls.kind = mdfts_pkg::K_IMAGE;
        else if (a == mdfts_pkg::CH_LBRACK)
            cls.kind = mdfts_pkg::K_LINK;
        else if (b == mdfts_pkg::CH_DQUOTE)
        begin
            cls.off  = 1'b1;
            cls.kind = (a == mdfts_pkg::CH_SPACE) ? mdfts_pkg::K_DQL : mdfts_pkg::K_DQR;
        end
        else if (b == mdfts_pkg::CH_SQUOTE)
        begin
            cls.off  = 1'b1;
            cls.kind = (a == mdfts_pkg::CH_SPACE) ? mdfts_pkg::K_SQL : mdfts_pkg::K_SQR;
        end
        else if (a == mdfts_pkg::CH_DOLLAR && b == mdfts_pkg::CH_DOLLAR
                 && c == mdfts_pkg::CH_DOLLAR)
            cls.kind = mdfts_pkg::K_MATH;
    end

endmodule

// ===== hw/rtl/mdfts_scan.sv =====
// ----------------------------------------------------------------------------
// mdfts_scan
// Line state: three pending bytes, byte count, first match. A nonzero byte into
// a full window tests the oldest offset; the end byte tests the rest and clears.
// ----------------------------------------------------------------------------
module mdfts_scan
#(
    parameter int MAX_LINE = mdfts_pkg::MAX_LINE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  mdfts_pkg::char_t    char_code,
    output mdfts_pkg::result_t  result
);

    localparam int POS_W = $clog2(MAX_LINE + 9);
    localparam logic [POS_W-1:0] LINE_MAX = POS_W'(MAX_LINE);
    localparam logic [POS_W-1:0] LINE_SAT = POS_W'(MAX_LINE + 8);

    mdfts_pkg::char_t   win_reg [3];
    mdfts_pkg::char_t   win_next [3];
    logic [1:0]         fill_reg, fill_next;
    logic [POS_W-1:0]   bpos_reg, bpos_next;
    mdfts_pkg::scan_st_t st_reg, st_next;

    logic [POS_W-1:0]   bpos_inc;
    logic [POS_W-1:0]   p_norm;
    logic [POS_W-1:0]   p_base;
    logic [POS_W-1:0]   p_d1;
    logic [POS_W-1:0]   p_d2;
    mdfts_pkg::class_t  cls_n, cls_d0, cls_d1, cls_d2;
    mdfts_pkg::scan_st_t st_norm, st_d0, st_d1, st_d2;

    mdfts_classify u_cls_n
    (
        .a   (win_reg[0]),
        .b   (win_reg[1]),
        .c   (win_reg[2]),
        .d   (char_code),
        .cls (cls_n)
    );

    mdfts_classify u_cls_d0
    (
        .a   (win_reg[0]),
        .b   (win_reg[1]),
        .c   (win_reg[2]),
        .d   (mdfts_pkg::CH_NUL),
        .cls (cls_d0)
    );

    mdfts_classify u_cls_d1
    (
        .a   (win_reg[1]),
        .b   (win_reg[2]),
        .c   (mdfts_pkg::CH_NUL),
        .d   (mdfts_pkg::CH_NUL),
        .cls (cls_d1)
    );

    mdfts_classify u_cls_d2
    (
        .a   (win_reg[2]),
        .b   (mdfts_pkg::CH_NUL),
        .c   (mdfts_pkg::CH_NUL),
        .d   (mdfts_pkg::CH_NUL),
        .cls (cls_d2)
    );

    always_comb
    begin
        bpos_inc = (bpos_reg < LINE_SAT) ? bpos_reg + POS_W'(1) : bpos_reg;
        p_norm   = bpos_inc - POS_W'(4);
        st_norm  = mdfts_pkg::examine_step(st_reg, win_reg[0], cls_n,
                                           p_norm < LINE_MAX, mdfts_pkg::tpos_t'(p_norm));

        // end of line: remaining offsets, slots beyond the fill hold zero
        p_base = bpos_reg - POS_W'(fill_reg);
        p_d1   = p_base + POS_W'(1);
        p_d2   = p_base + POS_W'(2);
        st_d0  = (fill_reg > 2'd0)
            ? mdfts_pkg::examine_step(st_reg, win_reg[0], cls_d0,
                                      p_base < LINE_MAX, mdfts_pkg::tpos_t'(p_base))
            : st_reg;
        st_d1  = (fill_reg > 2'd1)
            ? mdfts_pkg::examine_step(st_d0, win_reg[1], cls_d1,
                                      p_d1 < LINE_MAX, mdfts_pkg::tpos_t'(p_d1))
            : st_d0;
        st_d2  = (fill_reg > 2'd2)
            ? mdfts_pkg::examine_step(st_d1, win_reg[2], cls_d2,
                                      p_d2 < LINE_MAX, mdfts_pkg::tpos_t'(p_d2))
            : st_d1;

        result.kind     = st_d2.found ? st_d2.kind : mdfts_pkg::K_NONE;
        result.pos      = st_d2.found ? st_d2.pos : '0;
        result.too_long = !st_d2.found && (bpos_reg > LINE_MAX);

        win_next  = win_reg;
        fill_next = fill_reg;
        bpos_next = bpos_reg;
        st_next   = st_reg;
        if (step)
        begin
            if (char_code != mdfts_pkg::CH_NUL)
            begin
                bpos_next = bpos_inc;
                if (fill_reg == 2'd3)
                begin
                    st_next     = st_norm;
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    win_next[2] = char_code;
                end
                else
                begin
                    win_next[fill_reg] = char_code;
                    fill_next          = fill_reg + 2'd1;
                end
            end
            else
            begin
                win_next  = '{default: mdfts_pkg::CH_NUL};
                fill_next = '0;
                bpos_next = '0;
                st_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '{default: mdfts_pkg::CH_NUL};
            fill_reg <= '0;
            bpos_reg <= '0;
            st_reg   <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
            bpos_reg <= bpos_next;
            st_reg   <= st_next;
        end
    end

endmodule

// ===== hw/rtl/markdown_first_token_scanner.sv =====
// ----------------------------------------------------------------------------
// markdown_first_token_scanner
// Finds the first markdown token of a zero-terminated line of bytes.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, set by the combinational window match, while
// no zero byte waits on m_tready. The zero byte and then its result are registered.
// Only the zero byte produces a result; m_tready stalls only zero bytes.
// Reset: rst_n clears the line state and both valid flags at once.
module markdown_first_token_scanner
#(
    parameter int MAX_LINE = mdfts_pkg::MAX_LINE_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mdfts_pkg::CHAR_W-1:0]       s_tdata,    // char_code[7:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mdfts_pkg::M_TDATA_W-1:0]    m_tdata     // token_kind[4:0],
                                                           // token_pos[16:5],
                                                           // line_too_long[17], zero
);

    logic               in_valid_reg, in_valid_next;
    mdfts_pkg::char_t   in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    mdfts_pkg::result_t out_reg;
    mdfts_pkg::result_t result;
    logic               s_xfer;
    logic               adv;
    logic               is_end;

    assign is_end   = (in_byte_reg == mdfts_pkg::CH_NUL);
    assign adv      = in_valid_reg && (!is_end || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_xfer   = s_tvalid && s_tready;

    assign in_valid_next  = s_xfer ? 1'b1 : (adv ? 1'b0 : in_valid_reg);
    assign out_valid_next = (adv && is_end) ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    mdfts_scan
    #(
        .MAX_LINE (MAX_LINE)
    )
    u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (adv),
        .char_code (in_byte_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_byte_reg <= s_tdata;
        end
        if (adv && is_end)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mdfts_pkg::M_TDATA_W - $bits(mdfts_pkg::result_t)){1'b0}}, out_reg};

endmodule

// ===== hw/rtl/mdfts_checker.sv =====
// ----------------------------------------------------------------------------
// mdfts_checker
// Port-level checks of the token scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdfts_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [mdfts_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int PAD_LO = mdfts_pkg::KIND_W + mdfts_pkg::TOKEN_POS_W + 1;

    logic [mdfts_pkg::KIND_W-1:0]      kind;
    logic [mdfts_pkg::TOKEN_POS_W-1:0] pos;
    logic                              too_long;
    logic [mdfts_pkg::M_TDATA_W-1:PAD_LO] pad;

    assign kind     = m_tdata[mdfts_pkg::KIND_W-1:0];
    assign pos      = m_tdata[mdfts_pkg::KIND_W +: mdfts_pkg::TOKEN_POS_W];
    assign too_long = m_tdata[mdfts_pkg::KIND_W + mdfts_pkg::TOKEN_POS_W];
    assign pad      = m_tdata[mdfts_pkg::M_TDATA_W-1:PAD_LO];

    `ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPLY(a_pad_zero, clk, rst_n, m_tvalid, pad == '0)
    `ASSERT_IMPLY(a_none_pos, clk, rst_n, m_tvalid && kind == mdfts_pkg::K_NONE, pos == '0)
    `ASSERT_IMPLY(a_long_none, clk, rst_n, m_tvalid && too_long, kind == mdfts_pkg::K_NONE)
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, !s_tready, m_tvalid && !m_tready)

endmodule

bind markdown_first_token_scanner mdfts_checker u_mdfts_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams zero-terminated lines into markdown_first_token_scanner and checks
// each reported token (kind, position, overflow flag) against a line scanner
// kept in the bench. Covers every token kind, the digit-run, hash and
// backslash corner cases, a long output stall and randomized lines, with
// random idle cycles on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LINE_MAX        = mdfts_pkg::MAX_LINE_DEF;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int RANDOM_BYTES    = 1000;
    localparam int HOLD_CYCLES     = 300;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [mdfts_pkg::CHAR_W-1:0]    s_tdata;     // char_code[7:0]
    logic                            m_tvalid;
    logic                            m_tready;
    logic [mdfts_pkg::M_TDATA_W-1:0] m_tdata;     // token_kind[4:0], token_pos[16:5],
                                                  // line_too_long[17], zero

    markdown_first_token_scanner dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // line scanner state
    mdfts_pkg::char_t       win [4];
    int                     win_fill;
    int                     line_len;
    logic                   hit;
    mdfts_pkg::token_kind_t hit_kind;
    int                     hit_pos;
    logic                   in_digits;
    int                     digits_start;

    mdfts_pkg::result_t     expected_tokens [$];

    int          src_idle_max  = 10;
    int          sink_idle_max = 10;
    int          hold_len      = 0;
    int          bytes_sent    = 0;
    int          lines_sent    = 0;
    int          results_seen  = 0;
    int          mismatches    = 0;
    int          idle_cycles   = 0;
    logic [27:0] kinds_seen    = '0;

    string char_pool = "\\><!-#*=~+\t _\140&|[$\"'0123456789.)ax";

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic is_digit(mdfts_pkg::char_t c);
        return (c >= mdfts_pkg::CH_ZERO) && (c <= mdfts_pkg::CH_NINE);
    endfunction

    function automatic mdfts_pkg::token_kind_t match_pattern(
        mdfts_pkg::char_t a, mdfts_pkg::char_t b, mdfts_pkg::char_t c, mdfts_pkg::char_t d,
        output logic off);
        off = 1'b0;
        if (a == mdfts_pkg::CH_BSLASH && b != mdfts_pkg::CH_BSLASH) return mdfts_pkg::K_ESCAPE;
        if (a == mdfts_pkg::CH_GT) return mdfts_pkg::K_QBLOCK;
        if (a == mdfts_pkg::CH_SPACE && b == mdfts_pkg::CH_SPACE && c == mdfts_pkg::CH_NUL)
            return mdfts_pkg::K_LBREAK;
        if (a == mdfts_pkg::CH_LT && b == mdfts_pkg::CH_BANG
            && c == mdfts_pkg::CH_DASH && d == mdfts_pkg::CH_DASH)
            return mdfts_pkg::K_COPEN;
        if (a == mdfts_pkg::CH_DASH && b == mdfts_pkg::CH_DASH && c == mdfts_pkg::CH_GT)
            return mdfts_pkg::K_CCLOSE;
        if ((a == mdfts_pkg::CH_DASH && b == mdfts_pkg::CH_DASH && c == mdfts_pkg::CH_DASH) ||
            (a == mdfts_pkg::CH_STAR && b == mdfts_pkg::CH_STAR && c == mdfts_pkg::CH_STAR))
            return mdfts_pkg::K_RULE;
        if (a == mdfts_pkg::CH_HASH && b != mdfts_pkg::CH_HASH) return mdfts_pkg::K_H1;
        if (a == mdfts_pkg::CH_HASH && b == mdfts_pkg::CH_HASH && c != mdfts_pkg::CH_HASH)
            return mdfts_pkg::K_H2;
        if (a == mdfts_pkg::CH_HASH && b == mdfts_pkg::CH_HASH
            && c == mdfts_pkg::CH_HASH && d != mdfts_pkg::CH_HASH)
            return mdfts_pkg::K_H3;
        if (a == mdfts_pkg::CH_EQ && b == mdfts_pkg::CH_EQ && c == mdfts_pkg::CH_EQ)
            return mdfts_pkg::K_H1LINE;
        if (a == mdfts_pkg::CH_STAR && b != mdfts_pkg::CH_STAR) return mdfts_pkg::K_ITALIC;
        if (a == mdfts_pkg::CH_STAR && b == mdfts_pkg::CH_STAR) return mdfts_pkg::K_BOLD;
        if (a == mdfts_pkg::CH_TILDE && b == mdfts_pkg::CH_TILDE) return mdfts_pkg::K_STRIKE;
        if (a == mdfts_pkg::CH_PLUS || a == mdfts_pkg::CH_DASH) return mdfts_pkg::K_ITEM;
        if (a == mdfts_pkg::CH_TAB ||
            (a == mdfts_pkg::CH_SPACE && b == mdfts_pkg::CH_SPACE
             && c == mdfts_pkg::CH_SPACE && d == mdfts_pkg::CH_SPACE))
            return mdfts_pkg::K_TAB;
        if (a == mdfts_pkg::CH_UNDER && b != mdfts_pkg::CH_UNDER) return mdfts_pkg::K_UNDER;
        if (a == mdfts_pkg::CH_BTICK && b == mdfts_pkg::CH_BTICK && c == mdfts_pkg::CH_BTICK)
            return mdfts_pkg::K_CODE;
        if (a == mdfts_pkg::CH_AMP) return mdfts_pkg::K_AMP;
        if (a == mdfts_pkg::CH_PIPE) return mdfts_pkg::K_COLSEP;
        if (a == mdfts_pkg::CH_BANG && b == mdfts_pkg::CH_LBRACK) return mdfts_pkg::K_IMAGE;
        if (a == mdfts_pkg::CH_LBRACK) return mdfts_pkg::K_LINK;
        if (b == mdfts_pkg::CH_DQUOTE)
        begin
            off = 1'b1;
            return (a == mdfts_pkg::CH_SPACE) ? mdfts_pkg::K_DQL : mdfts_pkg::K_DQR;
        end
        if (b == mdfts_pkg::CH_SQUOTE)
        begin
            off = 1'b1;
            return (a == mdfts_pkg::CH_SPACE) ? mdfts_pkg::K_SQL : mdfts_pkg::K_SQR;
        end
        if (a == mdfts_pkg::CH_DOLLAR && b == mdfts_pkg::CH_DOLLAR && c == mdfts_pkg::CH_DOLLAR)
            return mdfts_pkg::K_MATH;
        return mdfts_pkg::K_NONE;
    endfunction

    function void clear_line();
        win          = '{default: mdfts_pkg::CH_NUL};
        win_fill     = 0;
        line_len     = 0;
        hit          = 1'b0;
        hit_kind     = mdfts_pkg::K_NONE;
        hit_pos      = 0;
        in_digits    = 1'b0;
        digits_start = 0;
    endfunction

    // Tests the offset held in window slot 0.
    function void scan_offset(int p);
        mdfts_pkg::token_kind_t k;
        logic                   off;
        if (hit || p >= LINE_MAX) return;
        if (in_digits)
        begin
            if (is_digit(win[0])) return;
            in_digits = 1'b0;
            if (win[0] == mdfts_pkg::CH_DOT || win[0] == mdfts_pkg::CH_RPAREN)
            begin
                hit      = 1'b1;
                hit_kind = mdfts_pkg::K_ENUM;
                hit_pos  = digits_start;
                return;
            end
        end
        if (is_digit(win[0]))
        begin
            in_digits    = 1'b1;
            digits_start = p;
            return;
        end
        k = match_pattern(win[0], win[1], win[2], win[3], off);
        if (k != mdfts_pkg::K_NONE)
        begin
            hit      = 1'b1;
            hit_kind = k;
            hit_pos  = p + int'(off);
        end
    endfunction

    function void shift_win();
        win[0] = win[1];
        win[1] = win[2];
        win[2] = win[3];
        win[3] = mdfts_pkg::CH_NUL;
        if (win_fill > 0) win_fill--;
    endfunction

    function void track_char(mdfts_pkg::char_t c);
        mdfts_pkg::result_t r;
        if (c != mdfts_pkg::CH_NUL)
        begin
            if (line_len < LINE_MAX + 8) line_len++;
            if (win_fill > 3) win_fill = 3;
            win[win_fill] = c;
            win_fill++;
            if (win_fill == 4)
            begin
                scan_offset(line_len - 4);
                shift_win();
            end
            return;
        end
        while (win_fill > 0)
        begin
            for (int i = win_fill; i < 4; i++) win[i] = mdfts_pkg::CH_NUL;
            scan_offset(line_len - win_fill);
            shift_win();
        end
        r.kind     = hit ? hit_kind : mdfts_pkg::K_NONE;
        r.pos      = hit ? mdfts_pkg::tpos_t'(hit_pos) : mdfts_pkg::tpos_t'(0);
        r.too_long = !hit && (line_len > LINE_MAX);
        expected_tokens.push_back(r);
        lines_sent++;
        clear_line();
    endfunction

    task automatic send_char(input mdfts_pkg::char_t c);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        track_char(c);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) send_char(mdfts_pkg::char_t'(s[i]));
        send_char(mdfts_pkg::CH_NUL);
    endtask

    // result sink
    initial
    begin
        int n;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_len > 0)
            begin
                n        = hold_len;
                hold_len = 0;
            end
            else
                n = $urandom_range(0, sink_idle_max);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        mdfts_pkg::result_t got;
        mdfts_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = mdfts_pkg::result_t'(m_tdata[17:0]);
            results_seen++;
            kinds_seen[got.kind] = 1'b1;
            if (expected_tokens.size() == 0)
            begin
                if (mismatches < 10)
                    $display("error: unexpected result kind %0d pos %0d long %0b",
                             got.kind, got.pos, got.too_long);
                mismatches++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (got.kind != want.kind || got.pos != want.pos ||
                    got.too_long != want.too_long)
                begin
                    if (mismatches < 10)
                        $display({"error: result %0d expected kind %0d pos %0d long %0b,",
                                  " got kind %0d pos %0d long %0b"},
                                 results_seen, want.kind, want.pos, want.too_long,
                                 got.kind, got.pos, got.too_long);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_CYCLES);
            $display("markdown_first_token_scanner: mismatch");
            $finish;
        end
    end

    task automatic test_token_kinds();
        send_line("\\a");
        send_line(">q");
        send_line("a  ");
        send_line("<!--");
        send_line("-->");
        send_line("---");
        send_line("***");
        send_line("#x");
        send_line("##x");
        send_line("###x");
        send_line("===");
        send_line("*a");
        send_line("**a");
        send_line("~~");
        send_line("+a");
        send_line("-a");
        send_line("\tx");
        send_line("    x");
        send_line("_a");
        send_line("\140\140\140");
        send_line("&");
        send_line("12.");
        send_line("7)");
        send_line("|");
        send_line("![");
        send_line("[");
        send_line(" \"");
        send_line("a\"");
        send_line(" '");
        send_line("a'");
        send_line("$$$");
    endtask

    task automatic test_special_cases();
        send_line("");
        send_line("\\\\");
        send_line("\\\\a");
        send_line("####");
        send_line("#####a");
        send_line("123a");
        send_line("x99)");
        send_line("0");
        send_line("45-");
        send_line("----");
        send_line("__a");
        send_line("ab");
        send_char(8'hFF);
        send_char(8'h80);
        send_char(mdfts_pkg::CH_NUL);
    endtask

    task automatic test_backpressure();
        src_idle_max = 0;
        hold_len     = HOLD_CYCLES;
        repeat (25) send_line("#a");
        src_idle_max = 10;
    endtask

    task automatic test_random_lines();
        int               start;
        int               len;
        int               n;
        mdfts_pkg::char_t c;
        start = bytes_sent;
        n     = 0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            if (n % 8 == 0)
            begin
                src_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 10;
                sink_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            end
            len = $urandom_range(0, 24);
            repeat (len)
            begin
                if ($urandom_range(0, 9) < 7)
                    c = mdfts_pkg::char_t'(char_pool[$urandom_range(0, char_pool.len() - 1)]);
                else
                    c = mdfts_pkg::char_t'($urandom_range(1, 255));
                send_char(c);
            end
            send_char(mdfts_pkg::CH_NUL);
            n++;
        end
        src_idle_max  = 10;
        sink_idle_max = 10;
    endtask

    initial
    begin
        clear_line();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = mdfts_pkg::CH_NUL;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_token_kinds();
        test_special_cases();
        test_backpressure();
        test_random_lines();

        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d bytes in %0d lines: all token kinds, corner cases, a long stall",
                 bytes_sent, lines_sent);
        $display("checked %0d results, %0d of 28 token kinds seen, %0d mismatches",
                 results_seen, $countones(kinds_seen), mismatches);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("markdown_first_token_scanner: match");
        else
            $display("markdown_first_token_scanner: mismatch");
        $finish;
    end

endmodule
